@@ hdl/sfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types, operation codes, flash opcodes and result builders for the
// SPI flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcs_pkg;

  // Result beat kinds
  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_DATA    = 2'd3
  } kind_e;

  // Completion status
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BUSY    = 2'd1,
    ERR_IDLE_RX = 2'd2
  } err_e;

  // Input operation codes
  localparam logic [3:0] OP_RDSR   = 4'd0;
  localparam logic [3:0] OP_WRSR   = 4'd1;
  localparam logic [3:0] OP_E4K    = 4'd2;
  localparam logic [3:0] OP_E32K   = 4'd3;
  localparam logic [3:0] OP_E64K   = 4'd4;
  localparam logic [3:0] OP_ECHIP  = 4'd5;
  localparam logic [3:0] OP_PROG   = 4'd6;
  localparam logic [3:0] OP_READ   = 4'd7;
  localparam logic [3:0] OP_RDID   = 4'd8;
  localparam logic [3:0] OP_RX     = 4'd9;

  // Flash opcodes
  localparam logic [7:0] OPC_WRSR  = 8'h01;
  localparam logic [7:0] OPC_PROG  = 8'h02;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_E4K   = 8'h20;
  localparam logic [7:0] OPC_EWSR  = 8'h50;
  localparam logic [7:0] OPC_E32K  = 8'h52;
  localparam logic [7:0] OPC_ECHIP = 8'h60;
  localparam logic [7:0] OPC_RDID  = 8'h90;
  localparam logic [7:0] OPC_E64K  = 8'hd8;

  // One input beat
  typedef struct packed {
    logic [3:0]  operation;
    logic [23:0] address;
    logic [7:0]  write_data;
    logic [16:0] byte_count;
    logic [7:0]  rx_byte;
  } item_t;

  // One result beat (last is added at the output)
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [15:0] gap_before;
    logic [7:0]  read_value;
    logic [7:0]  device_id;
    err_e        error;
  } result_t;

  // Up to three results caused by one input beat, first in slot 0
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } batch_t;

  function automatic result_t send_beat(input logic [7:0] tx, input logic [15:0] gap);
    result_t b;
    b            = '0;
    b.kind       = KIND_SEND;
    b.tx_byte    = tx;
    b.gap_before = gap;
    b.error      = ERR_NONE;
    return b;
  endfunction

  function automatic result_t release_beat();
    result_t b;
    b       = '0;
    b.kind  = KIND_RELEASE;
    b.error = ERR_NONE;
    return b;
  endfunction

  function automatic result_t done_beat(input logic [7:0] rv, input logic [7:0] dev,
                                        input err_e err);
    result_t b;
    b            = '0;
    b.kind       = KIND_DONE;
    b.read_value = rv;
    b.device_id  = dev;
    b.error      = err;
    return b;
  endfunction

  function automatic result_t data_beat(input logic [7:0] rv);
    result_t b;
    b            = '0;
    b.kind       = KIND_DATA;
    b.read_value = rv;
    b.error      = ERR_NONE;
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sfcs_seq.sv @@
// ----------------------------------------------------------------------------
// sfcs_seq
// Command sequencer state and the single-pass step logic: from the current
// step and one registered input beat it forms the batch of result beats and
// the next step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcs_seq #(
  parameter int MAX_READ_BYTES = 65536,
  parameter int ADDRESS_BITS   = 24
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fire_i,
  input  sfcs_pkg::item_t     item_i,
  input  wire          [15:0] select_gap_i,
  output sfcs_pkg::batch_t    batch_o
);
  import sfcs_pkg::*;

  localparam int          AddrBytes = (ADDRESS_BITS + 7) / 8;
  localparam logic [24:0] MaxRead   = 25'(MAX_READ_BYTES);

  // Step codes
  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_WREN      = 5'd1;
  localparam logic [4:0] ST_OPC       = 5'd2;
  localparam logic [4:0] ST_ADDR      = 5'd3;
  localparam logic [4:0] ST_LASTCMD   = 5'd8;
  localparam logic [4:0] ST_POLLCMD   = 5'd9;
  localparam logic [4:0] ST_POLL      = 5'd10;
  localparam logic [4:0] ST_RDSR_CMD  = 5'd11;
  localparam logic [4:0] ST_RDSR_DATA = 5'd12;
  localparam logic [4:0] ST_EWSR      = 5'd13;
  localparam logic [4:0] ST_WRSR_CMD  = 5'd14;
  localparam logic [4:0] ST_WRSR_VAL  = 5'd15;
  localparam logic [4:0] ST_DATA      = 5'd16;
  localparam logic [4:0] ST_MFR       = 5'd17;
  localparam logic [4:0] ST_DEV       = 5'd18;

  logic [4:0]  st_q, st_d;
  logic [3:0]  op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [7:0]  val_q, val_d;
  logic [16:0] left_q, left_d;
  logic [7:0]  id_q, id_d;

  logic        in_addr;
  logic [2:0]  addr_n;
  logic [1:0]  addr_sel;
  logic [31:0] addr_ext;
  logic [7:0]  addr_byte;
  logic [16:0] left_dec;
  logic [16:0] count_clamped;
  logic [7:0]  rx;
  logic [7:0]  main_opc;

  // Address phase decode
  always_comb begin
    in_addr   = (st_q >= ST_OPC) && (st_q < 5'(int'(ST_ADDR) + AddrBytes));
    addr_n    = (st_q == ST_OPC) ? 3'd0 : 3'(st_q - ST_ADDR + 5'd1);
    addr_sel  = 2'(AddrBytes - 1 - int'(addr_n));
    addr_ext  = {8'h00, addr_q};
    addr_byte = addr_ext[{addr_sel, 3'b000} +: 8];
  end

  // Misc helpers
  always_comb begin
    rx       = item_i.rx_byte;
    left_dec = (left_q != 17'd0) ? left_q - 17'd1 : 17'd0;
    if ({8'h00, item_i.byte_count} > MaxRead) begin
      count_clamped = MaxRead[16:0];
    end else begin
      count_clamped = item_i.byte_count;
    end
    case (op_q)
      OP_E4K:   main_opc = OPC_E4K;
      OP_E32K:  main_opc = OPC_E32K;
      OP_E64K:  main_opc = OPC_E64K;
      OP_ECHIP: main_opc = OPC_ECHIP;
      default:  main_opc = OPC_PROG;
    endcase
  end

  // Step logic
  always_comb begin
    batch_o = '0;
    st_d    = st_q;
    op_d    = op_q;
    addr_d  = addr_q;
    val_d   = val_q;
    left_d  = left_q;
    id_d    = id_q;
    if (item_i.operation == OP_RX) begin
      if (st_q == ST_IDLE) begin
        batch_o.res[0] = done_beat(8'h00, 8'h00, ERR_IDLE_RX);
        batch_o.count  = 2'd1;
      end else if (in_addr) begin
        if (addr_n != 3'(AddrBytes)) begin
          batch_o.res[0] = send_beat(addr_byte, 16'd0);
          batch_o.count  = 2'd1;
          st_d           = ST_ADDR + {2'b00, addr_n};
        end else begin
          // address sent: continue with the operation's tail
          case (op_q)
            OP_PROG: begin
              batch_o.res[0] = send_beat(val_q, 16'd0);
              batch_o.count  = 2'd1;
              st_d           = ST_LASTCMD;
            end
            OP_READ: begin
              if (left_q == 17'd0) begin
                batch_o.res[0] = release_beat();
                batch_o.res[1] = done_beat(8'h00, 8'h00, ERR_NONE);
                batch_o.count  = 2'd2;
                st_d           = ST_IDLE;
              end else begin
                batch_o.res[0] = send_beat(8'h00, 16'd0);
                batch_o.count  = 2'd1;
                st_d           = ST_DATA;
              end
            end
            OP_RDID: begin
              batch_o.res[0] = send_beat(8'h00, 16'd0);
              batch_o.count  = 2'd1;
              st_d           = ST_MFR;
            end
            default: begin
              batch_o.res[0] = release_beat();
              batch_o.res[1] = send_beat(OPC_RDSR, 16'd0);
              batch_o.count  = 2'd2;
              st_d           = ST_POLLCMD;
            end
          endcase
        end
      end else begin
        unique case (st_q)
          ST_WREN: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = send_beat(main_opc, 16'd0);
            batch_o.count  = 2'd2;
            st_d           = (op_q == OP_ECHIP) ? ST_LASTCMD : ST_OPC;
          end
          ST_LASTCMD: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = send_beat(OPC_RDSR, 16'd0);
            batch_o.count  = 2'd2;
            st_d           = ST_POLLCMD;
          end
          ST_POLLCMD: begin
            batch_o.res[0] = send_beat(8'h00, 16'd0);
            batch_o.count  = 2'd1;
            st_d           = ST_POLL;
          end
          ST_POLL: begin
            // keep polling while busy is set
            if (rx[0]) begin
              batch_o.res[0] = send_beat(8'h00, 16'd0);
              batch_o.count  = 2'd1;
            end else begin
              batch_o.res[0] = release_beat();
              batch_o.res[1] = done_beat(rx, 8'h00, ERR_NONE);
              batch_o.count  = 2'd2;
              st_d           = ST_IDLE;
            end
          end
          ST_RDSR_CMD: begin
            batch_o.res[0] = send_beat(8'h00, 16'd0);
            batch_o.count  = 2'd1;
            st_d           = ST_RDSR_DATA;
          end
          ST_RDSR_DATA: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = done_beat(rx, 8'h00, ERR_NONE);
            batch_o.count  = 2'd2;
            st_d           = ST_IDLE;
          end
          ST_EWSR: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = send_beat(OPC_WRSR, select_gap_i);
            batch_o.count  = 2'd2;
            st_d           = ST_WRSR_CMD;
          end
          ST_WRSR_CMD: begin
            batch_o.res[0] = send_beat(val_q, 16'd0);
            batch_o.count  = 2'd1;
            st_d           = ST_WRSR_VAL;
          end
          ST_WRSR_VAL: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = done_beat(8'h00, 8'h00, ERR_NONE);
            batch_o.count  = 2'd2;
            st_d           = ST_IDLE;
          end
          ST_DATA: begin
            batch_o.res[0] = data_beat(rx);
            left_d         = left_dec;
            if (left_dec != 17'd0) begin
              batch_o.res[1] = send_beat(8'h00, 16'd0);
              batch_o.count  = 2'd2;
            end else begin
              batch_o.res[1] = release_beat();
              batch_o.res[2] = done_beat(8'h00, 8'h00, ERR_NONE);
              batch_o.count  = 2'd3;
              st_d           = ST_IDLE;
            end
          end
          ST_MFR: begin
            id_d           = rx;
            batch_o.res[0] = send_beat(8'h00, 16'd0);
            batch_o.count  = 2'd1;
            st_d           = ST_DEV;
          end
          ST_DEV: begin
            batch_o.res[0] = release_beat();
            batch_o.res[1] = done_beat(id_q, rx, ERR_NONE);
            batch_o.count  = 2'd2;
            st_d           = ST_IDLE;
          end
          default: begin
            batch_o.res[0] = done_beat(8'h00, 8'h00, ERR_IDLE_RX);
            batch_o.count  = 2'd1;
            st_d           = ST_IDLE;
          end
        endcase
      end
    end else if (item_i.operation <= OP_RDID) begin
      if (st_q != ST_IDLE) begin
        batch_o.res[0] = done_beat(8'h00, 8'h00, ERR_BUSY);
        batch_o.count  = 2'd1;
      end else begin
        // start a new command
        op_d          = item_i.operation;
        addr_d        = item_i.address;
        val_d         = item_i.write_data;
        batch_o.count = 2'd1;
        case (item_i.operation)
          OP_RDSR: begin
            batch_o.res[0] = send_beat(OPC_RDSR, 16'd0);
            st_d           = ST_RDSR_CMD;
          end
          OP_WRSR: begin
            batch_o.res[0] = send_beat(OPC_EWSR, 16'd0);
            st_d           = ST_EWSR;
          end
          OP_READ: begin
            left_d         = count_clamped;
            batch_o.res[0] = send_beat(OPC_READ, 16'd0);
            st_d           = ST_OPC;
          end
          OP_RDID: begin
            addr_d         = 24'd0;
            batch_o.res[0] = send_beat(OPC_RDID, 16'd0);
            st_d           = ST_OPC;
          end
          default: begin
            batch_o.res[0] = send_beat(OPC_WREN, 16'd0);
            st_d           = ST_WREN;
          end
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      op_q   <= 4'd0;
      addr_q <= 24'd0;
      val_q  <= 8'd0;
      left_q <= 17'd0;
      id_q   <= 8'd0;
    end else if (fire_i) begin
      st_q   <= st_d;
      op_q   <= op_d;
      addr_q <= addr_d;
      val_q  <= val_d;
      left_q <= left_d;
      id_q   <= id_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/spi_flash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// Turns flash commands and received SPI bytes into send, release-select,
// data and done beats for a byte-level SPI master.
// ----------------------------------------------------------------------------
// An input beat is captured in an input register, worked in one pass by the
// step logic and its up to three result beats loaded into a three-entry
// result register that drains one beat per cycle while out_stall_i is low;
// last marks the final beat of each input beat. A result passes the input
// register, then the result register, which holds the next input beat back
// until its last beat is taken; the single output port draining it thus sets
// the sustained rate. Beats for unknown operations pass through with no
// result. No memories, no clearing pass.
`default_nettype none

module spi_flash_command_sequencer #(
  parameter int MAX_READ_BYTES = 65536,
  parameter int ADDRESS_BITS   = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // configuration
  input  wire               cfg_we_i,
  input  wire        [15:0] cfg_wdata_i,
  // input channel
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire        [3:0]  operation_i,
  input  wire        [23:0] address_i,
  input  wire        [7:0]  write_data_i,
  input  wire        [16:0] byte_count_i,
  input  wire        [7:0]  rx_byte_i,
  // result channel
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic       [1:0]  kind_o,
  output logic       [7:0]  tx_byte_o,
  output logic       [15:0] gap_before_o,
  output logic       [7:0]  read_value_o,
  output logic       [7:0]  device_id_o,
  output logic       [1:0]  error_o,
  output logic              last_o
);
  import sfcs_pkg::*;

  logic          in_vq;
  item_t         item_q;
  logic [15:0]   gap_q;
  result_t [2:0] rbuf_q;
  logic [1:0]    cnt_q;
  logic          in_accept;
  logic          pop;
  logic          buf_free;
  logic          fire;
  batch_t        batch;

  // Handshake
  assign pop       = out_valid_o && !out_stall_i;
  assign buf_free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign fire      = in_vq && buf_free;
  assign in_stall_o = in_vq && !fire;
  assign in_accept = in_valid_i && !in_stall_o;

  // Select gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 16'd100;
    end else if (cfg_we_i) begin
      gap_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_accept) begin
      in_vq <= 1'b1;
    end else if (fire) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{operation:  operation_i,
                  address:    address_i,
                  write_data: write_data_i,
                  byte_count: byte_count_i,
                  rx_byte:    rx_byte_i};
    end
  end

  // Step logic
  sfcs_seq #(
    .MAX_READ_BYTES (MAX_READ_BYTES),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (item_q),
    .select_gap_i (gap_q),
    .batch_o      (batch)
  );

  // Result register: load a batch, else shift out one beat per pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (fire) begin
      cnt_q <= batch.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rbuf_q <= batch.res;
    end else if (pop) begin
      rbuf_q[0] <= rbuf_q[1];
      rbuf_q[1] <= rbuf_q[2];
    end
  end

  // Result port
  assign out_valid_o  = (cnt_q != 2'd0);
  assign kind_o       = rbuf_q[0].kind;
  assign tx_byte_o    = rbuf_q[0].tx_byte;
  assign gap_before_o = rbuf_q[0].gap_before;
  assign read_value_o = rbuf_q[0].read_value;
  assign device_id_o  = rbuf_q[0].device_id;
  assign error_o      = rbuf_q[0].error;
  assign last_o       = (cnt_q == 2'd1);

  // Checks
  a_batch_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (batch.count != 2'd0) |=> out_valid_o)
    else $error("loaded result batch not presented");

  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (batch.res[0].error != ERR_NONE) |-> batch.count == 2'd1)
    else $error("error done not a single-beat result");

  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA) |-> !last_o)
    else $error("data beat marked last");

endmodule

`default_nettype wire

@@ dv/tb_spi_flash_command_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_flash_command_sequencer
// Self-checking bench for the SPI flash command sequencer. A short table of
// commands and received bytes comes first. Random command sequences follow,
// fed with received bytes, under several select-gap settings, with random
// idling on both channels and one long output hold-off. A read with an
// over-range count, fed a few bytes, closes the run. Every result beat is
// checked against a sequence tracker kept inside the bench.
// ----------------------------------------------------------------------------

module tb_spi_flash_command_sequencer;
  import sfcs_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int MAX_READ_BYTES = 65536;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // operation codes the block ignores
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // position within a flash command sequence
  typedef enum logic [4:0] {
    S_IDLE, S_WREN, S_OPC, S_ADDR0, S_ADDR1, S_ADDR2, S_LASTCMD, S_POLLCMD,
    S_POLL, S_RDSR_CMD, S_RDSR_DATA, S_EWSR, S_WRSR_CMD, S_WRSR_VAL, S_DATA,
    S_MFR, S_DEV
  } seq_step_e;

  typedef struct packed {
    result_t beat;
    logic    last;
  } exp_beat_t;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  operation_i;
  logic [23:0] address_i;
  logic [7:0]  write_data_i;
  logic [16:0] byte_count_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [15:0] gap_before_o;
  logic [7:0]  read_value_o;
  logic [7:0]  device_id_o;
  logic [1:0]  error_o;
  logic        last_o;

  // tracker state, mirrors the sequencer
  seq_step_e   seq_step;
  logic [3:0]  seq_op;
  logic [23:0] seq_addr;
  logic [7:0]  seq_value;
  logic [16:0] seq_remaining;
  logic [7:0]  seq_mfr_id;
  logic [15:0] gap_setting;

  result_t     pending_beats[$];
  exp_beat_t   expected_beats[$];
  dir_row_t    directed_rows[$];

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned cmd_rotor = 0;
  logic        want_wrsr = 1'b0;
  logic        sender_idle_on = 1'b1;
  logic        receiver_idle_on = 1'b1;
  logic        hold_request = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  spi_flash_command_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .byte_count_i (byte_count_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .gap_before_o (gap_before_o),
    .read_value_o (read_value_o),
    .device_id_o  (device_id_o),
    .error_o      (error_o),
    .last_o       (last_o)
  );

  // --------------------------------------------------------------------------
  // Sequence tracker
  // --------------------------------------------------------------------------
  function automatic result_t make_beat(input kind_e k, input logic [7:0] tx,
                                        input logic [15:0] gap, input logic [7:0] rv,
                                        input logic [7:0] dev, input err_e e);
    result_t b;
    b            = '0;
    b.kind       = k;
    b.tx_byte    = tx;
    b.gap_before = gap;
    b.read_value = rv;
    b.device_id  = dev;
    b.error      = e;
    return b;
  endfunction

  task automatic queue_send(input logic [7:0] tx, input logic [15:0] gap,
                            input seq_step_e nxt);
    pending_beats.push_back(make_beat(KIND_SEND, tx, gap, 8'h00, 8'h00, ERR_NONE));
    seq_step = nxt;
  endtask

  task automatic queue_release();
    pending_beats.push_back(make_beat(KIND_RELEASE, 8'h00, 16'h0000, 8'h00, 8'h00,
                                      ERR_NONE));
  endtask

  task automatic queue_done(input logic [7:0] rv, input logic [7:0] dev, input err_e e);
    pending_beats.push_back(make_beat(KIND_DONE, 8'h00, 16'h0000, rv, dev, e));
    seq_step = S_IDLE;
  endtask

  // one received byte moves the sequence on by one SPI byte
  task automatic advance(input logic [7:0] rx);
    case (seq_step)
      S_OPC:   queue_send(seq_addr[23:16], 16'h0000, S_ADDR0);
      S_ADDR0: queue_send(seq_addr[15:8], 16'h0000, S_ADDR1);
      S_ADDR1: queue_send(seq_addr[7:0], 16'h0000, S_ADDR2);
      S_ADDR2: begin
        // address complete: what follows depends on the command
        if (seq_op == OP_PROG) begin
          queue_send(seq_value, 16'h0000, S_LASTCMD);
        end else if (seq_op == OP_READ) begin
          if (seq_remaining == 0) begin
            queue_release();
            queue_done(8'h00, 8'h00, ERR_NONE);
          end else begin
            queue_send(8'h00, 16'h0000, S_DATA);
          end
        end else if (seq_op == OP_RDID) begin
          queue_send(8'h00, 16'h0000, S_MFR);
        end else begin
          queue_release();
          queue_send(OPC_RDSR, 16'h0000, S_POLLCMD);
        end
      end
      S_WREN: begin
        queue_release();
        case (seq_op)
          OP_E4K:   queue_send(OPC_E4K, 16'h0000, S_OPC);
          OP_E32K:  queue_send(OPC_E32K, 16'h0000, S_OPC);
          OP_E64K:  queue_send(OPC_E64K, 16'h0000, S_OPC);
          OP_ECHIP: queue_send(OPC_ECHIP, 16'h0000, S_LASTCMD);
          default:  queue_send(OPC_PROG, 16'h0000, S_OPC);
        endcase
      end
      S_LASTCMD: begin
        queue_release();
        queue_send(OPC_RDSR, 16'h0000, S_POLLCMD);
      end
      S_POLLCMD: queue_send(8'h00, 16'h0000, S_POLL);
      S_POLL: begin
        // keep polling while the busy bit is set
        if (rx[0]) begin
          queue_send(8'h00, 16'h0000, S_POLL);
        end else begin
          queue_release();
          queue_done(rx, 8'h00, ERR_NONE);
        end
      end
      S_RDSR_CMD: queue_send(8'h00, 16'h0000, S_RDSR_DATA);
      S_RDSR_DATA: begin
        queue_release();
        queue_done(rx, 8'h00, ERR_NONE);
      end
      S_EWSR: begin
        queue_release();
        queue_send(OPC_WRSR, gap_setting, S_WRSR_CMD);
      end
      S_WRSR_CMD: queue_send(seq_value, 16'h0000, S_WRSR_VAL);
      S_WRSR_VAL: begin
        queue_release();
        queue_done(8'h00, 8'h00, ERR_NONE);
      end
      S_DATA: begin
        pending_beats.push_back(make_beat(KIND_DATA, 8'h00, 16'h0000, rx, 8'h00,
                                          ERR_NONE));
        if (seq_remaining > 0) seq_remaining = seq_remaining - 1'b1;
        if (seq_remaining > 0) begin
          queue_send(8'h00, 16'h0000, S_DATA);
        end else begin
          queue_release();
          queue_done(8'h00, 8'h00, ERR_NONE);
        end
      end
      S_MFR: begin
        seq_mfr_id = rx;
        queue_send(8'h00, 16'h0000, S_DEV);
      end
      S_DEV: begin
        queue_release();
        queue_done(seq_mfr_id, rx, ERR_NONE);
      end
      default: ;
    endcase
  endtask

  // work out the result beats of one accepted input beat
  task automatic predict(input item_t it);
    logic [16:0] count;
    pending_beats.delete();
    if (it.operation == OP_RX) begin
      if (seq_step == S_IDLE) queue_done(8'h00, 8'h00, ERR_IDLE_RX);
      else advance(it.rx_byte);
    end else if (it.operation <= OP_RDID) begin
      if (seq_step != S_IDLE) begin
        pending_beats.push_back(make_beat(KIND_DONE, 8'h00, 16'h0000, 8'h00, 8'h00,
                                          ERR_BUSY));
      end else begin
        count = (it.byte_count > MAX_READ_BYTES) ? 17'(MAX_READ_BYTES) : it.byte_count;
        seq_op    = it.operation;
        seq_addr  = it.address;
        seq_value = it.write_data;
        case (it.operation)
          OP_RDSR: queue_send(OPC_RDSR, 16'h0000, S_RDSR_CMD);
          OP_WRSR: queue_send(OPC_EWSR, 16'h0000, S_EWSR);
          OP_READ: begin
            seq_remaining = count;
            queue_send(OPC_READ, 16'h0000, S_OPC);
          end
          OP_RDID: begin
            seq_addr = '0;
            queue_send(OPC_RDID, 16'h0000, S_OPC);
          end
          default: queue_send(OPC_WREN, 16'h0000, S_WREN);
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // idle stretch: mostly none or short, now and then long
  function automatic int unsigned idle_len(input logic on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic item_t make_item(input logic [3:0] op);
    item_t it;
    it.operation  = op;
    it.address    = 24'($urandom);
    it.write_data = 8'($urandom);
    it.rx_byte    = 8'($urandom);
    // reads stay short; other commands carry a full-width count
    if (op == OP_READ) begin
      if ($urandom_range(0, 7) == 0) it.byte_count = 17'($urandom_range(7, 40));
      else it.byte_count = 17'($urandom_range(0, 6));
    end else begin
      it.byte_count = 17'($urandom);
    end
    return it;
  endfunction

  // mostly well-formed sequences, with stray bytes, busy commands and noise
  function automatic item_t next_stimulus();
    int unsigned r;
    logic [3:0]  op;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else if (seq_step == S_IDLE) begin
      if (r < 12) begin
        op = OP_RX;
      end else if (want_wrsr) begin
        op = OP_WRSR;
        want_wrsr = 1'b0;
      end else if (cmd_rotor <= OP_RDID) begin
        op = 4'(cmd_rotor);
        cmd_rotor++;
      end else begin
        op = 4'($urandom_range(OP_RDSR, OP_RDID));
      end
    end else begin
      if (r < 12) op = 4'($urandom_range(OP_RDSR, OP_RDID));
      else op = OP_RX;
    end
    return make_item(op);
  endfunction

  // present one beat, wait for it to be taken, then queue its results
  task automatic offer(input item_t it, input logic typed, input result_t want);
    int unsigned gap;
    gap = idle_len(sender_idle_on);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= it.operation;
    address_i    <= it.address;
    write_data_i <= it.write_data;
    byte_count_i <= it.byte_count;
    rx_byte_i    <= it.rx_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(it);
    if (pending_beats.size() > 0) begin
      if (typed) begin
        expected_beats.push_back('{beat: want, last: 1'b1});
      end else begin
        foreach (pending_beats[i]) begin
          expected_beats.push_back('{beat: pending_beats[i],
                                     last: (i == pending_beats.size() - 1)});
        end
      end
    end
  endtask

  // stop offering and let every expected beat arrive
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_select_gap(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_setting = value;
  endtask

  task automatic random_phase(input int unsigned n_items);
    item_t       it;
    int unsigned taken;
    taken = 0;
    want_wrsr = 1'b1;
    while (taken < n_items) begin
      it = next_stimulus();
      offer(it, 1'b0, '0);
      if (it.operation <= OP_RX) taken++;
    end
  endtask

  task automatic add_row(input logic [3:0] op, input logic [23:0] addr,
                         input logic [7:0] wd, input logic [16:0] cnt,
                         input logic [7:0] rx, input logic typed, input result_t want);
    dir_row_t row;
    row.stim.operation  = op;
    row.stim.address    = addr;
    row.stim.write_data = wd;
    row.stim.byte_count = cnt;
    row.stim.rx_byte    = rx;
    row.typed           = typed;
    row.want            = want;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    item_t it;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    operation_i  = '0;
    address_i    = '0;
    write_data_i = '0;
    byte_count_i = '0;
    rx_byte_i    = '0;
    seq_step      = S_IDLE;
    seq_op        = '0;
    seq_addr      = '0;
    seq_value     = '0;
    seq_remaining = '0;
    seq_mfr_id    = '0;
    gap_setting   = 16'd100;

    // stray byte and status read straight after reset, then every command
    // while busy
    add_row(OP_RX, 24'h000000, 8'h00, 17'h00000, 8'hff, 1'b1,
            make_beat(KIND_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, ERR_IDLE_RX));
    add_row(OP_RDSR, 24'hffffff, 8'hff, 17'h1ffff, 8'h00, 1'b1,
            make_beat(KIND_SEND, OPC_RDSR, 16'h0000, 8'h00, 8'h00, ERR_NONE));
    for (int op = OP_WRSR; op <= OP_RDID; op++) begin
      add_row(4'(op), (op % 2) ? 24'hffffff : 24'h000000, 8'hff, 17'h1ffff, 8'h00, 1'b1,
              make_beat(KIND_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, ERR_BUSY));
    end
    add_row(OP_UNUSED_HI, 24'hffffff, 8'hff, 17'h1ffff, 8'hff, 1'b0, '0);
    add_row(OP_UNUSED_LO, 24'h000000, 8'h00, 17'h00000, 8'h00, 1'b0, '0);
    add_row(OP_RX, 24'h000000, 8'h00, 17'h00000, 8'h00, 1'b0, '0);
    add_row(OP_RX, 24'h000000, 8'h00, 17'h00000, 8'h5a, 1'b0, '0);
    // write status with the reset select gap
    add_row(OP_WRSR, 24'h000000, 8'hff, 17'h00001, 8'h00, 1'b0, '0);
    for (int i = 0; i < 3; i++) add_row(OP_RX, 24'h0, 8'h0, 17'h0, 8'hff, 1'b0, '0);
    // chip erase, one busy poll then clear
    add_row(OP_ECHIP, 24'h000000, 8'h00, 17'h00000, 8'h00, 1'b0, '0);
    for (int i = 0; i < 3; i++) add_row(OP_RX, 24'h0, 8'h0, 17'h0, 8'h00, 1'b0, '0);
    add_row(OP_RX, 24'h000000, 8'h00, 17'h00000, 8'h01, 1'b0, '0);
    add_row(OP_RX, 24'h000000, 8'h00, 17'h00000, 8'hfe, 1'b0, '0);
    // read with zero count at the top address
    add_row(OP_READ, 24'hffffff, 8'h00, 17'h00000, 8'h00, 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(OP_RX, 24'h0, 8'h0, 17'h0, 8'h33, 1'b0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    // zero gap, idling on both sides
    drain();
    write_select_gap(16'h0000);
    random_phase(25);

    // widest gap, no idling at all
    drain();
    write_select_gap(16'hffff);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    random_phase(25);

    // random gap; output held off for a long stretch while beats keep coming
    drain();
    write_select_gap(16'($urandom_range(1, 16'hfffe)));
    receiver_idle_on = 1'b1;
    hold_request     = 1'b1;
    random_phase(25);

    // one read with an over-range count, clamped; a few data bytes, no idling
    drain();
    receiver_idle_on = 1'b0;
    while (seq_step != S_IDLE) offer(make_item(OP_RX), 1'b0, '0);
    it = make_item(OP_READ);
    it.byte_count = 17'h1ffff;
    offer(it, 1'b0, '0);
    for (int i = 0; i < 8; i++) offer(make_item(OP_RX), 1'b0, '0);

    drain();
    if (mismatches == 0) begin
      $display("tb_spi_flash_command_sequencer OK");
    end else begin
      $display("tb_spi_flash_command_sequencer NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side stall: random runs, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned run;
    run = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (receiver_idle_on && ($urandom_range(0, 2) == 0)) begin
        out_stall_i <= 1'b1;
        run = idle_len(1'b1);
      end else begin
        out_stall_i <= 1'b0;
        run = $urandom_range(0, 4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    exp_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: kind 0x%0h", kind_o);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        check_field("kind", e.beat.kind, kind_o);
        check_field("tx_byte", e.beat.tx_byte, tx_byte_o);
        check_field("gap_before", e.beat.gap_before, gap_before_o);
        check_field("read_value", e.beat.read_value, read_value_o);
        check_field("device_id", e.beat.device_id, device_id_o);
        check_field("error", e.beat.error, error_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  // watchdog: too long without any beat moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_spi_flash_command_sequencer NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
